FILE: rtl/rsbk_pkg.sv
// Shared constants and helpers for the record sort block.
`default_nettype none
package rsbk_pkg;
    localparam int REC_DEPTH = 1024;
    localparam int NAME_CHUNKS = 17;
    localparam int AW = $clog2(REC_DEPTH);
    localparam int CW = AW + 1;
    localparam int NAW = $clog2(REC_DEPTH * NAME_CHUNKS);
    localparam int CIW = $clog2(NAME_CHUNKS + 1);
    localparam int DATE_W = 23;

    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_CHUNK = 3'd1;
    localparam logic [2:0] KIND_SORT = 3'd2;
    localparam logic [2:0] KIND_READ = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_DATE = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [1:0] KEY_DATE = 2'd0;
    localparam logic [1:0] KEY_NAME = 2'd1;
    localparam logic [1:0] KEY_NONE = 2'd3;

    // days in a month, month given 1..12
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        begin
            case (m)
                4'd2: d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
                default: d = 5'd31;
            endcase
            return d;
        end
    endfunction

    // flat address of one name chunk of a record
    function automatic logic [NAW-1:0] name_addr(input logic [AW-1:0] rec,
                                                 input logic [CIW-1:0] c);
        begin
            return NAW'(rec) * NAW'(NAME_CHUNKS) + NAW'(c);
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/record_sort_by_key_top.sv
// Record store with stable bottom-up merge sort and sorted read-out.
// Sort runs roughly n*log2(n) merge steps; a step compares by date or price, or by
// name chunk by chunk until the chunks differ, and copy steps move leftover entries;
// one word in flight at a time, the next word taken once its result is registered out.
// Reset: synchronous active low; clears count, read pointer and flags. Stores
// hold no reset value; a load zeroes its 17 name chunks.
`default_nettype none
module record_sort_by_key_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_key_select,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [6:0]  i_day,
    input  wire logic [6:0]  i_month,
    input  wire logic [13:0] i_year,
    input  wire logic [39:0] i_price_cents,
    input  wire logic [63:0] i_name_chunk,
    input  wire logic [4:0]  i_chunk_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [9:0]       o_position,
    output logic [4:0]       o_out_day,
    output logic [3:0]       o_out_month,
    output logic [13:0]      o_out_year,
    output logic [39:0]      o_out_price_cents,
    output logic             o_last
);
    localparam int AW = rsbk_pkg::AW;
    localparam int CW = rsbk_pkg::CW;
    localparam int NAW = rsbk_pkg::NAW;
    localparam int CIW = rsbk_pkg::CIW;
    localparam int DW = rsbk_pkg::DATE_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ZERO = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_RUN = 4'd3;
    localparam logic [3:0] S_STEP = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_COPY = 4'd6;
    localparam logic [3:0] S_CMP = 4'd7;
    localparam logic [3:0] S_PUT = 4'd8;
    localparam logic [3:0] S_NRA = 4'd9;
    localparam logic [3:0] S_NRB = 4'd10;
    localparam logic [3:0] S_NCMP = 4'd11;
    localparam logic [3:0] S_RD1 = 4'd12;
    localparam logic [3:0] S_RD2 = 4'd13;
    localparam logic [3:0] S_RD3 = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    // memories: record fields, names, and two order banks used ping-pong
    logic [DW-1:0] date_mem [rsbk_pkg::REC_DEPTH];
    logic [39:0]   price_mem [rsbk_pkg::REC_DEPTH];
    logic [63:0]   name_mem [rsbk_pkg::REC_DEPTH * rsbk_pkg::NAME_CHUNKS];
    logic [AW-1:0] ord0_mem [rsbk_pkg::REC_DEPTH];
    logic [AW-1:0] ord1_mem [rsbk_pkg::REC_DEPTH];

    logic [3:0]     r_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_rp;
    logic           r_invalid;
    logic           r_sorted;
    logic           r_open;
    logic [1:0]     r_cfg_key;
    logic [1:0]     r_key;
    logic           r_src;
    logic [CW:0]    r_w;
    logic [CW:0]    r_i;
    logic [CW-1:0]  r_mid;
    logic [CW-1:0]  r_end;
    logic [CW-1:0]  r_p;
    logic [CW-1:0]  r_q;
    logic [CW-1:0]  r_k;
    logic           r_fromq;
    logic           r_keep;
    logic [AW-1:0]  r_a;
    logic [AW-1:0]  r_b;
    logic [CIW-1:0] r_c;
    logic [63:0]    r_wa;

    logic [2:0]  r_res_status;
    logic [9:0]  r_res_pos;
    logic [DW-1:0] r_res_date;
    logic [39:0] r_res_price;
    logic        r_res_last;

    logic        r_o_valid;
    logic [2:0]  r_o_status;
    logic [9:0]  r_o_pos;
    logic [DW-1:0] r_o_date;
    logic [39:0] r_o_price;
    logic        r_o_last;

    logic [AW-1:0] ord0_rd_a, ord0_rd_b, ord1_rd_a, ord1_rd_b;
    logic [AW-1:0] ord_rd_a, ord_rd_b;
    logic [DW-1:0] date_rd_a, date_rd_b;
    logic [39:0]   price_rd_a, price_rd_b;
    logic [63:0]   name_rd;

    logic          accept;
    logic          date_ok;
    logic          load_ok;
    logic          chunk_ok;
    logic [29:0]   y_prod;
    logic [10:0]   y_q25;
    logic          y_div25;
    logic          leap;
    logic [AW-1:0] ord_ra;
    logic          merge_we;
    logic [AW-1:0] merge_wd;
    logic          ord0_we, ord1_we;
    logic [AW-1:0] ord_wa, ord_wd;
    logic          nm_we;
    logic [NAW-1:0] nm_wa, nm_ra;
    logic [63:0]   nm_wd;
    logic          n_decided, n_keep;
    logic [CW:0]   n_w2;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign accept = i_valid && o_ready;

    // date check: year mod 25 by reciprocal multiply, then leap rule
    always_comb begin
        y_prod = 30'(i_year) * 30'd20972;
        y_q25 = y_prod[29:19];
        y_div25 = (16'(y_q25) * 16'd25) == 16'(i_year);
        leap = (i_year[3:0] == 4'd0 && y_div25) || (i_year[1:0] == 2'd0 && !y_div25);
        date_ok = (i_month >= 7'd1) && (i_month <= 7'd12) && (i_day >= 7'd1)
            && (i_day <= 7'(rsbk_pkg::month_days(i_month[3:0], leap)));
    end

    assign load_ok = accept && i_kind == rsbk_pkg::KIND_LOAD && date_ok
        && r_count < CW'(rsbk_pkg::REC_DEPTH);
    assign chunk_ok = accept && i_kind == rsbk_pkg::KIND_CHUNK && r_open
        && r_count != '0 && i_chunk_index < 5'(rsbk_pkg::NAME_CHUNKS);

    // order banks: init fills bank 0; merges read the source bank, write the other one
    assign ord_ra = (r_state == S_RD1) ? r_rp[AW-1:0] : r_p[AW-1:0];
    assign ord_rd_a = r_src ? ord1_rd_a : ord0_rd_a;
    assign ord_rd_b = r_src ? ord1_rd_b : ord0_rd_b;
    assign merge_we = (r_state == S_COPY) || (r_state == S_PUT);
    assign merge_wd = (r_state == S_COPY) ? (r_fromq ? ord_rd_b : ord_rd_a)
                                          : (r_keep ? r_a : r_b);
    assign ord0_we = (r_state == S_INIT && r_i < (CW+1)'(r_count)) || (merge_we && r_src);
    assign ord1_we = merge_we && !r_src;
    assign ord_wa = (r_state == S_INIT) ? r_i[AW-1:0] : r_k[AW-1:0];
    assign ord_wd = (r_state == S_INIT) ? r_i[AW-1:0] : merge_wd;

    always_ff @(posedge i_clk) begin
        if (ord0_we) ord0_mem[ord_wa] <= ord_wd;
        ord0_rd_a <= ord0_mem[ord_ra];
        ord0_rd_b <= ord0_mem[r_q[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ord1_we) ord1_mem[ord_wa] <= ord_wd;
        ord1_rd_a <= ord1_mem[ord_ra];
        ord1_rd_b <= ord1_mem[r_q[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            date_mem[r_count[AW-1:0]] <= {i_year, i_month[3:0], i_day[4:0]};
            price_mem[r_count[AW-1:0]] <= i_price_cents;
        end
        date_rd_a <= date_mem[ord_rd_a];
        date_rd_b <= date_mem[ord_rd_b];
        price_rd_a <= price_mem[ord_rd_a];
        price_rd_b <= price_mem[ord_rd_b];
    end

    // name store: zero fill after load, chunk writes, compare reads
    always_comb begin
        nm_we = (r_state == S_ZERO) || chunk_ok;
        if (r_state == S_ZERO) begin
            nm_wa = rsbk_pkg::name_addr(r_count[AW-1:0], r_c);
            nm_wd = '0;
        end else begin
            nm_wa = rsbk_pkg::name_addr(AW'(r_count - CW'(1)), i_chunk_index);
            nm_wd = i_name_chunk;
        end
        nm_ra = rsbk_pkg::name_addr((r_state == S_NRA) ? r_a : r_b, r_c);
    end

    always_ff @(posedge i_clk) begin
        if (nm_we) name_mem[nm_wa] <= nm_wd;
        name_rd <= name_mem[nm_ra];
    end

    // bytewise compare of one chunk pair, stop at first difference or zero
    always_comb begin
        n_decided = 1'b0;
        n_keep = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (!n_decided) begin
                if (r_wa[63-8*k -: 8] != name_rd[63-8*k -: 8]) begin
                    n_decided = 1'b1;
                    n_keep = r_wa[63-8*k -: 8] < name_rd[63-8*k -: 8];
                end else if (r_wa[63-8*k -: 8] == 8'd0) begin
                    n_decided = 1'b1;
                end
            end
        end
    end

    assign n_w2 = {r_w[CW-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rp <= '0;
            r_invalid <= 1'b0;
            r_sorted <= 1'b0;
            r_open <= 1'b0;
            r_cfg_key <= rsbk_pkg::KEY_DATE;
            r_src <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cfg_key <= i_cfg_key_select;
            // fill the output register when a word is ready, drop it once taken
            if (r_state == S_EMIT && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_pos <= '0;
                        r_res_date <= '0;
                        r_res_price <= '0;
                        r_res_last <= 1'b0;
                        case (i_kind)
                            rsbk_pkg::KIND_LOAD: begin
                                r_sorted <= 1'b0;
                                r_rp <= '0;
                                if (!date_ok) begin
                                    r_invalid <= 1'b1;
                                    r_open <= 1'b0;
                                    r_res_status <= rsbk_pkg::ST_BAD_DATE;
                                    r_state <= S_EMIT;
                                end else if (!load_ok) begin
                                    r_open <= 1'b0;
                                    r_res_status <= rsbk_pkg::ST_FULL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_res_status <= rsbk_pkg::ST_OK;
                                    r_c <= '0;
                                    r_state <= S_ZERO;
                                end
                            end
                            rsbk_pkg::KIND_CHUNK: begin
                                r_res_status <= rsbk_pkg::ST_OK;
                                r_state <= S_EMIT;
                                if (chunk_ok) begin
                                    r_sorted <= 1'b0;
                                    r_rp <= '0;
                                end
                            end
                            rsbk_pkg::KIND_SORT: begin
                                if (r_invalid) begin
                                    r_res_status <= rsbk_pkg::ST_INVALID;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_res_status <= rsbk_pkg::ST_OK;
                                    r_key <= r_cfg_key;
                                    r_src <= 1'b0;
                                    r_i <= '0;
                                    r_state <= S_INIT;
                                end
                            end
                            rsbk_pkg::KIND_READ: begin
                                if (r_invalid) begin
                                    r_res_status <= rsbk_pkg::ST_INVALID;
                                    r_state <= S_EMIT;
                                end else if (!r_sorted || r_rp >= r_count) begin
                                    r_res_status <= rsbk_pkg::ST_EMPTY;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_res_status <= rsbk_pkg::ST_OK;
                                    r_state <= S_RD1;
                                end
                            end
                            rsbk_pkg::KIND_CLEAR: begin
                                r_res_status <= rsbk_pkg::ST_OK;
                                r_state <= S_EMIT;
                                r_count <= '0;
                                r_rp <= '0;
                                r_invalid <= 1'b0;
                                r_sorted <= 1'b0;
                                r_open <= 1'b0;
                            end
                            default: begin
                                r_res_status <= rsbk_pkg::ST_OK;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_ZERO: begin
                    r_c <= r_c + CIW'(1);
                    if (r_c == CIW'(rsbk_pkg::NAME_CHUNKS - 1)) begin
                        r_count <= r_count + CW'(1);
                        r_open <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_INIT: begin
                    if (r_i < (CW+1)'(r_count)) begin
                        r_i <= r_i + (CW+1)'(1);
                    end else if (r_key == rsbk_pkg::KEY_NONE || r_count <= CW'(1)) begin
                        r_sorted <= 1'b1;
                        r_rp <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_w <= (CW+1)'(1);
                        r_i <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_i >= (CW+1)'(r_count)) begin
                        // pass done: swap banks, double run width
                        r_src <= !r_src;
                        r_w <= n_w2;
                        r_i <= '0;
                        if (n_w2 >= (CW+1)'(r_count)) begin
                            r_sorted <= 1'b1;
                            r_rp <= '0;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_mid <= (r_i + r_w < (CW+1)'(r_count)) ?
                            CW'(r_i + r_w) : r_count;
                        r_end <= (r_i + n_w2 < (CW+1)'(r_count)) ?
                            CW'(r_i + n_w2) : r_count;
                        r_p <= CW'(r_i);
                        r_q <= CW'(r_i + r_w);
                        r_k <= CW'(r_i);
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_p < r_mid && r_q < r_end) begin
                        r_state <= S_FETCH;
                    end else if (r_p < r_mid) begin
                        r_fromq <= 1'b0;
                        r_state <= S_COPY;
                    end else if (r_q < r_end) begin
                        r_fromq <= 1'b1;
                        r_state <= S_COPY;
                    end else begin
                        r_i <= r_i + n_w2;
                        r_state <= S_RUN;
                    end
                end
                S_COPY: begin
                    r_k <= r_k + CW'(1);
                    if (r_fromq) r_q <= r_q + CW'(1);
                    else r_p <= r_p + CW'(1);
                    r_state <= S_STEP;
                end
                S_FETCH: begin
                    r_a <= ord_rd_a;
                    r_b <= ord_rd_b;
                    r_c <= '0;
                    r_state <= (r_key == rsbk_pkg::KEY_NAME) ? S_NRA : S_CMP;
                end
                S_CMP: begin
                    r_keep <= (r_key == rsbk_pkg::KEY_DATE) ? (date_rd_a <= date_rd_b)
                                                            : (price_rd_a <= price_rd_b);
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    r_k <= r_k + CW'(1);
                    if (r_keep) r_p <= r_p + CW'(1);
                    else r_q <= r_q + CW'(1);
                    r_state <= S_STEP;
                end
                S_NRA: begin
                    r_state <= S_NRB;
                end
                S_NRB: begin
                    r_wa <= name_rd;
                    r_state <= S_NCMP;
                end
                S_NCMP: begin
                    if (n_decided || r_c == CIW'(rsbk_pkg::NAME_CHUNKS - 1)) begin
                        r_keep <= n_keep;
                        r_state <= S_PUT;
                    end else begin
                        r_c <= r_c + CIW'(1);
                        r_state <= S_NRA;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_a <= ord_rd_a;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_res_pos <= 10'(r_a);
                    r_res_date <= date_rd_a;
                    r_res_price <= price_rd_a;
                    r_res_last <= (r_rp + CW'(1)) == r_count;
                    r_rp <= r_rp + CW'(1);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register frees up
                    if (!r_o_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_o_valid || i_ready)) begin
            r_o_status <= r_res_status;
            r_o_pos <= r_res_pos;
            r_o_date <= r_res_date;
            r_o_price <= r_res_price;
            r_o_last <= r_res_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_status = r_o_status;
    assign o_position = r_o_pos;
    assign o_out_day = r_o_date[4:0];
    assign o_out_month = r_o_date[8:5];
    assign o_out_year = r_o_date[22:9];
    assign o_out_price_cents = r_o_price;
    assign o_last = r_o_last;
endmodule
`default_nettype wire
